@@ rtl/pnt_pkg.sv @@
// ----------------------------------------------------------------------------
// pnt_pkg: shared types and constants of the pose id tracker
// Holds the table sizes, the register indexes and the state codes that the
// controller and the distance unit use.
// ----------------------------------------------------------------------------
package pnt_pkg;

	// Table sizes.
	localparam int unsigned MaxPoses  = 32;
	localparam int unsigned NumJoints = 18;
	localparam int unsigned PoseW     = $clog2(MaxPoses);
	localparam int unsigned CountW    = $clog2(MaxPoses + 1);
	localparam int unsigned JointAw   = $clog2(2 * MaxPoses * NumJoints);
	localparam int unsigned IdAw      = $clog2(2 * MaxPoses);

	// Value limits.
	localparam logic [16:0] DistMax = 17'h1FFFF;
	localparam logic [21:0] SumMax  = 22'h3FFFFF;

	// floor(s / 18) = (s * MeanMul) >> MeanShift for every 22-bit s.
	localparam logic [21:0] MeanMul   = 22'd3728271;
	localparam int unsigned MeanShift = 26;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH     = 2'd0;
	localparam logic [1:0] REG_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_START,
		ST_WAIT,
		ST_STORE,
		ST_SMUL,
		ST_SCMP,
		ST_DECIDE,
		ST_IDRD,
		ST_EMIT
	} ctl_state_t;

	// Distance unit states.
	typedef enum logic [1:0] {
		DS_IDLE,
		DS_DIV,
		DS_SQ,
		DS_SQRT
	} dist_state_t;

endpackage

@@ rtl/pnt_dist_unit.sv @@
// ----------------------------------------------------------------------------
// pnt_dist_unit: iterative normalized joint distance
// Computes floor(sqrt(nx^2 + ny^2)) with nx = floor(|dx| * 4096 / W) and
// ny likewise, each saturated to Q5.12. Two restoring dividers run side by
// side, then one multiply stage and a restoring square root.
// ----------------------------------------------------------------------------
module pnt_dist_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] x,
	input  logic [15:0] y,
	input  logic [15:0] px,
	input  logic [15:0] py,
	input  logic [12:0] width,
	input  logic [12:0] height,
	output logic        done,
	output logic [16:0] result
);

	pnt_pkg::dist_state_t state_q, state_d;

	logic [4:0]  cnt_q;
	logic [12:0] rx_q, ry_q;
	logic [16:0] nx_q, ny_q;
	logic [16:0] qx_q, qy_q;
	logic        satx_q, saty_q;
	logic [34:0] v_q;
	logic [35:0] root_q;
	logic [34:0] bit_q;
	logic        done_q;
	logic [16:0] dist_q;

	logic [15:0] dx, dy;
	logic [13:0] rx2, ry2;
	logic        gex, gey;
	logic [16:0] fx, fy;
	logic [35:0] trial;
	logic [35:0] root_nx;

	// Absolute differences and one divider step per axis.
	assign dx    = (x > px) ? (x - px) : (px - x);
	assign dy    = (y > py) ? (y - py) : (py - y);
	assign rx2   = {rx_q, nx_q[16]};
	assign ry2   = {ry_q, ny_q[16]};
	assign gex   = rx2 >= {1'b0, width};
	assign gey   = ry2 >= {1'b0, height};
	assign fx    = satx_q ? pnt_pkg::DistMax : qx_q;
	assign fy    = saty_q ? pnt_pkg::DistMax : qy_q;
	assign trial = root_q + {1'b0, bit_q};

	// Root after the current square-root step.
	assign root_nx = ({1'b0, v_q} >= trial) ? (root_q >> 1) + {1'b0, bit_q} : root_q >> 1;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pnt_pkg::DS_IDLE: if (start) state_d = pnt_pkg::DS_DIV;
			pnt_pkg::DS_DIV:  if (cnt_q == 5'd0) state_d = pnt_pkg::DS_SQ;
			pnt_pkg::DS_SQ:   state_d = pnt_pkg::DS_SQRT;
			pnt_pkg::DS_SQRT: if (cnt_q == 5'd0) state_d = pnt_pkg::DS_IDLE;
			default:          state_d = pnt_pkg::DS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnt_pkg::DS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == pnt_pkg::DS_SQRT) && (cnt_q == 5'd0);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			pnt_pkg::DS_IDLE: begin
				cnt_q  <= 5'd16;
				rx_q   <= {2'b00, dx[15:5]};
				ry_q   <= {2'b00, dy[15:5]};
				nx_q   <= {dx[4:0], 12'd0};
				ny_q   <= {dy[4:0], 12'd0};
				qx_q   <= 17'd0;
				qy_q   <= 17'd0;
				satx_q <= {2'b00, dx} >= {width, 5'd0};
				saty_q <= {2'b00, dy} >= {height, 5'd0};
			end
			pnt_pkg::DS_DIV: begin
				cnt_q <= cnt_q - 5'd1;
				rx_q  <= gex ? 13'(rx2 - {1'b0, width}) : rx2[12:0];
				ry_q  <= gey ? 13'(ry2 - {1'b0, height}) : ry2[12:0];
				nx_q  <= {nx_q[15:0], 1'b0};
				ny_q  <= {ny_q[15:0], 1'b0};
				qx_q  <= {qx_q[15:0], gex};
				qy_q  <= {qy_q[15:0], gey};
			end
			pnt_pkg::DS_SQ: begin
				v_q    <= 35'({1'b0, 34'(fx * fx)} + {1'b0, 34'(fy * fy)});
				root_q <= 36'd0;
				bit_q  <= {1'b1, 34'd0};
				cnt_q  <= 5'd17;
			end
			pnt_pkg::DS_SQRT: begin
				cnt_q <= cnt_q - 5'd1;
				bit_q <= bit_q >> 2;
				if ({1'b0, v_q} >= trial) begin
					v_q    <= 35'({1'b0, v_q} - trial);
					root_q <= (root_q >> 1) + {1'b0, bit_q};
				end else begin
					root_q <= root_q >> 1;
				end
			end
			default: cnt_q <= cnt_q;
		endcase
		// The final step's root is taken as it is formed.
		if (state_q == pnt_pkg::DS_SQRT && cnt_q == 5'd0) begin
			dist_q <= (root_nx > {19'd0, pnt_pkg::DistMax}) ? pnt_pkg::DistMax
			                                               : root_nx[16:0];
		end
	end

	assign done   = done_q;
	assign result = dist_q;

endmodule

@@ rtl/pose_nearest_id_tracker.sv @@
// ----------------------------------------------------------------------------
// pose_nearest_id_tracker: nearest-neighbor pose id tracking
// Keypoints stream in one at a time; each is compared with the stored poses
// of the previous frame, and the last joint of a pose yields an id.
// ----------------------------------------------------------------------------
// Per keypoint: one pass of the shared divide and square-root unit for each
// stored previous pose, then a store step after its transfer. The last joint
// then adds a mean scan over the previous poses and a decide step, an id read
// when an id is reused, and an emit step that waits for a free output.
// Throughput: one item at a time; end of frame and ignored joints stay in idle.
// Reset clears counters, sums, bank select and id counter; memories get no clear.
// ----------------------------------------------------------------------------
module pose_nearest_id_tracker (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // joint[4:0], coord_x[20:5], coord_y[36:21], zero
	input  logic        s_tuser,  // mode
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // assigned_id[31:0], mean_distance[48:32], zero
	output logic [1:0]  m_tuser   // matched[0], stored[1]
);

	pnt_pkg::ctl_state_t state_q, state_d;

	// Configuration registers.
	logic [12:0] width_q, height_q;
	logic [15:0] thr_q;

	// Tracking state.
	logic [pnt_pkg::CountW-1:0] prev_cnt_q, cur_cnt_q;
	logic                       bank_q;
	logic [31:0]                id_ctr_q;
	logic [21:0]                sums_q [pnt_pkg::MaxPoses];

	// Current item.
	logic [4:0]                joint_q;
	logic [15:0]               x_q, y_q;
	logic [pnt_pkg::PoseW-1:0] k_q, best_k_q;
	logic [16:0]               best_q, mean_q;
	logic                      found_q;
	logic [31:0]               id_q;
	logic                      matched_q;

	// Memories.
	logic [31:0]                 jmem [2 * pnt_pkg::MaxPoses * pnt_pkg::NumJoints];
	logic [31:0]                 imem [2 * pnt_pkg::MaxPoses];
	logic [pnt_pkg::JointAw-1:0] jaddr;
	logic [31:0]                 jrdata;
	logic [pnt_pkg::IdAw-1:0]    iaddr;
	logic [31:0]                 irdata;
	logic                        jwe, iwe;

	// Output register.
	logic        out_v_q;
	logic [31:0] out_id_q;
	logic [16:0] out_mean_q;
	logic        out_match_q, out_stored_q;

	logic        in_xfer, room, last_k, is_last_joint, cur_free;
	logic [5:0]  jpose;
	logic [12:0] w_eff, h_eff;
	logic        dstart, ddone;
	logic [16:0] jdist;
	logic [22:0] sum_add;
	logic [43:0] mean_prod;
	logic [17:0] mean_raw;

	assign in_xfer       = s_tvalid && s_tready;
	assign room          = !out_v_q || m_tready;
	assign last_k        = ({1'b0, k_q} + 6'd1) == prev_cnt_q;
	assign is_last_joint = joint_q == 5'(pnt_pkg::NumJoints - 1);
	assign cur_free      = cur_cnt_q < 6'(pnt_pkg::MaxPoses);
	assign w_eff         = (width_q == 13'd0) ? 13'd1 : width_q;
	assign h_eff         = (height_q == 13'd0) ? 13'd1 : height_q;
	assign dstart        = state_q == pnt_pkg::ST_START;

	// Joint memory address: read the previous bank, write the current one.
	assign jpose = (state_q == pnt_pkg::ST_STORE) ? {bank_q, cur_cnt_q[pnt_pkg::PoseW-1:0]}
	                                              : {~bank_q, k_q};
	assign jaddr = 11'({jpose, 4'd0}) + 11'({jpose, 1'b0}) + 11'(joint_q);
	assign jwe   = (state_q == pnt_pkg::ST_STORE) && cur_free;
	assign iaddr = (state_q == pnt_pkg::ST_EMIT) ? {bank_q, cur_cnt_q[pnt_pkg::PoseW-1:0]}
	                                             : {~bank_q, best_k_q};
	assign iwe   = (state_q == pnt_pkg::ST_EMIT) && room && cur_free;

	assign sum_add   = {1'b0, sums_q[k_q]} + {6'd0, jdist};
	assign mean_prod = sums_q[k_q] * pnt_pkg::MeanMul;
	assign mean_raw  = mean_prod[pnt_pkg::MeanShift +: 18];

	pnt_dist_unit u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.x      (x_q),
		.y      (y_q),
		.px     (jrdata[31:16]),
		.py     (jrdata[15:0]),
		.width  (w_eff),
		.height (h_eff),
		.done   (ddone),
		.result (jdist)
	);

	// Memories with registered read data.
	always_ff @(posedge clk) begin
		if (jwe) jmem[jaddr] <= {x_q, y_q};
		jrdata <= jmem[jaddr];
	end

	always_ff @(posedge clk) begin
		if (iwe) imem[iaddr] <= id_q;
		irdata <= imem[iaddr];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pnt_pkg::ST_IDLE: begin
				if (in_xfer && !s_tuser && s_tdata[4:0] < 5'(pnt_pkg::NumJoints)) begin
					state_d = (prev_cnt_q == 6'd0) ? pnt_pkg::ST_STORE : pnt_pkg::ST_RD;
				end
			end
			pnt_pkg::ST_RD:    state_d = pnt_pkg::ST_START;
			pnt_pkg::ST_START: state_d = pnt_pkg::ST_WAIT;
			pnt_pkg::ST_WAIT: begin
				if (ddone) state_d = last_k ? pnt_pkg::ST_STORE : pnt_pkg::ST_RD;
			end
			pnt_pkg::ST_STORE: begin
				if (!is_last_joint) state_d = pnt_pkg::ST_IDLE;
				else if (prev_cnt_q == 6'd0) state_d = pnt_pkg::ST_DECIDE;
				else state_d = pnt_pkg::ST_SMUL;
			end
			pnt_pkg::ST_SMUL: state_d = pnt_pkg::ST_SCMP;
			pnt_pkg::ST_SCMP: state_d = last_k ? pnt_pkg::ST_DECIDE : pnt_pkg::ST_SMUL;
			pnt_pkg::ST_DECIDE: begin
				state_d = (found_q && best_q < {1'b0, thr_q}) ? pnt_pkg::ST_IDRD
				                                               : pnt_pkg::ST_EMIT;
			end
			pnt_pkg::ST_IDRD: state_d = pnt_pkg::ST_EMIT;
			pnt_pkg::ST_EMIT: if (room) state_d = pnt_pkg::ST_IDLE;
			default:          state_d = pnt_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pnt_pkg::ST_IDLE;
			width_q    <= 13'd1920;
			height_q   <= 13'd1080;
			thr_q      <= 16'd0;
			prev_cnt_q <= '0;
			cur_cnt_q  <= '0;
			bank_q     <= 1'b0;
			id_ctr_q   <= 32'd0;
			out_v_q    <= 1'b0;
			for (int i = 0; i < pnt_pkg::MaxPoses; i++) sums_q[i] <= 22'd0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					pnt_pkg::REG_WIDTH:     width_q  <= cfg_wdata[12:0];
					pnt_pkg::REG_HEIGHT:    height_q <= cfg_wdata[12:0];
					pnt_pkg::REG_THRESHOLD: thr_q    <= cfg_wdata;
					default:                thr_q    <= thr_q;
				endcase
			end
			// End of frame swaps the banks.
			if (state_q == pnt_pkg::ST_IDLE && in_xfer && s_tuser) begin
				bank_q     <= ~bank_q;
				prev_cnt_q <= cur_cnt_q;
				cur_cnt_q  <= '0;
			end
			if (state_q == pnt_pkg::ST_WAIT && ddone) begin
				sums_q[k_q] <= (joint_q == 5'd0) ? {5'd0, jdist} :
				               (sum_add > {1'b0, pnt_pkg::SumMax}) ? pnt_pkg::SumMax
				                                                   : sum_add[21:0];
			end
			if (state_q == pnt_pkg::ST_DECIDE && !(found_q && best_q < {1'b0, thr_q})) begin
				id_ctr_q <= id_ctr_q + 32'd1;
			end
			// The output register loads from emit and empties on its transfer.
			if (state_q == pnt_pkg::ST_EMIT && room) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			if (state_q == pnt_pkg::ST_EMIT && room && cur_free) begin
				cur_cnt_q <= cur_cnt_q + 6'd1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			pnt_pkg::ST_IDLE: begin
				joint_q <= s_tdata[4:0];
				x_q     <= s_tdata[20:5];
				y_q     <= s_tdata[36:21];
				k_q     <= '0;
			end
			pnt_pkg::ST_WAIT: if (ddone) k_q <= k_q + 5'd1;
			pnt_pkg::ST_STORE: begin
				k_q      <= '0;
				best_q   <= pnt_pkg::DistMax;
				best_k_q <= '0;
				found_q  <= 1'b0;
			end
			pnt_pkg::ST_SMUL: begin
				mean_q <= mean_raw[17] ? pnt_pkg::DistMax : mean_raw[16:0];
			end
			pnt_pkg::ST_SCMP: begin
				if (!found_q || mean_q < best_q) begin
					best_q   <= mean_q;
					best_k_q <= k_q;
				end
				found_q <= 1'b1;
				k_q     <= k_q + 5'd1;
			end
			pnt_pkg::ST_DECIDE: begin
				id_q      <= id_ctr_q + 32'd1;
				matched_q <= 1'b0;
			end
			pnt_pkg::ST_IDRD: begin
				id_q      <= irdata;
				matched_q <= 1'b1;
			end
			pnt_pkg::ST_EMIT: begin
				if (room) begin
					out_id_q     <= id_q;
					out_mean_q   <= best_q;
					out_match_q  <= matched_q;
					out_stored_q <= cur_free;
				end
			end
			default: k_q <= k_q;
		endcase
	end

	assign s_tready = state_q == pnt_pkg::ST_IDLE;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'd0, out_mean_q, out_id_q};
	assign m_tuser  = {out_stored_q, out_match_q};

	// The pose count of a bank never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_cnt_q <= 6'(pnt_pkg::MaxPoses) && prev_cnt_q <= 6'(pnt_pkg::MaxPoses))
		else $error("pose count beyond table size");

	// The distance unit only finishes while the controller waits for it.
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ddone |-> state_q == pnt_pkg::ST_WAIT)
		else $error("distance result outside wait state");

	// A new result is loaded only from the emit state.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_v_q || m_tready) && $past(1'b1) ##1 out_v_q && !$past(out_v_q && !m_tready)
		|-> $past(state_q) == pnt_pkg::ST_EMIT)
		else $error("result loaded outside emit state");

	// A pending result is never overwritten before its transfer.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !m_tready |=> out_v_q && $stable(out_id_q))
		else $error("pending result lost");

endmodule
